### hw/rtl/sidu_pkg.sv
package sidu_pkg;

	typedef logic [63:0] word_t;
	typedef logic [1:0] status_t;
	typedef logic [1:0] size_t;

	localparam status_t STATUS_OK = 2'd0;
	localparam status_t STATUS_DIV_ZERO = 2'd1;
	localparam status_t STATUS_OVERFLOW = 2'd2;

	localparam size_t SIZE_8 = 2'd0;
	localparam size_t SIZE_16 = 2'd1;
	localparam size_t SIZE_32 = 2'd2;
	localparam size_t SIZE_64 = 2'd3;

	typedef struct packed {
		word_t rem_next;
		logic  quo_bit;
	} step_res_t;

endpackage

### hw/rtl/sidu_div_step.sv
module sidu_div_step (
	input  sidu_pkg::word_t     rem,
	input  logic                next_bit,
	input  sidu_pkg::word_t     dmag,
	output sidu_pkg::step_res_t res
);

	// The partial remainder stays below the divisor magnitude, at most 2^63,
	// so shifting one bit in never loses its top bit.
	sidu_pkg::word_t shifted;
	logic [64:0]     diff;

	always_comb begin
		shifted = {rem[62:0], next_bit};
		diff = {1'b0, shifted} - {1'b0, dmag};
		res.quo_bit = ~diff[64];
		res.rem_next = diff[64] ? shifted : diff[63:0];
	end

endmodule

### hw/rtl/signed_integer_divide_unit.sv
// Signed integer divide unit with x86 IDIV semantics at 8, 16, 32 and 64 bits.
// The input channel (in_valid, in_ready) moves one transfer of op_size, the
// dividend halves and the divisor. The output channel (out_valid, out_ready)
// moves one transfer of quotient, remainder and status for every input.
// An item runs through the prep and check states, then the restoring divide
// loop, which runs one quotient bit a cycle through a single shared subtract
// and compare step, and then the fix state, which loads the output register.
// in_ready comes back high together with out_valid. A zero divisor, or a high
// dividend half not below the divisor magnitude, is found before the loop and
// skips it; a quotient beyond the signed range is found after the loop.
// The block takes one item at a time: in_ready is high only while no item is
// at work. A finished result sits in the output register; the next item may
// be transferred in while it waits, and that item holds in its last cycle
// until the output register is free.
// Reset (arst_n low) empties the block: no item at work and no result valid.
module signed_integer_divide_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sidu_pkg::size_t     op_size,
	input  sidu_pkg::word_t     dividend_low,
	input  sidu_pkg::word_t     dividend_high,
	input  sidu_pkg::word_t     divisor_value,
	output logic                out_valid,
	input  logic                out_ready,
	output sidu_pkg::word_t     quotient,
	output sidu_pkg::word_t     remainder,
	output sidu_pkg::status_t   status
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_DIV = 3'd3;
	localparam logic [2:0] ST_FIX = 3'd4;

	logic [2:0]          state_q;
	sidu_pkg::size_t     size_q;
	sidu_pkg::word_t     lo_q;
	sidu_pkg::word_t     hi_q;
	sidu_pkg::word_t     dv_q;
	sidu_pkg::word_t     rem_q;
	sidu_pkg::word_t     low_q;
	sidu_pkg::word_t     dmag_q;
	logic                vneg_q;
	logic                qneg_q;
	logic                zero_q;
	logic [6:0]          count_q;
	sidu_pkg::status_t   status_q;
	logic                out_valid_q;
	sidu_pkg::word_t     quotient_q;
	sidu_pkg::word_t     remainder_q;

	logic [127:0]        dvd_sx;
	logic [127:0]        dvd_mag;
	sidu_pkg::word_t     dv_sx;
	sidu_pkg::word_t     dv_mag;
	sidu_pkg::word_t     hi_part;
	sidu_pkg::word_t     low_part;
	logic [6:0]          width_n;
	sidu_pkg::step_res_t step;
	sidu_pkg::word_t     limit;
	sidu_pkg::word_t     mask;
	sidu_pkg::word_t     q_signed;
	sidu_pkg::word_t     r_signed;
	logic                in_fire;
	logic                out_free;

	assign in_fire = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign quotient = quotient_q;
	assign remainder = remainder_q;
	assign status = status_q;

	always_comb begin
		case (size_q)
			sidu_pkg::SIZE_8: begin
				dvd_sx = {{112{lo_q[15]}}, lo_q[15:0]};
				dv_sx = {{56{dv_q[7]}}, dv_q[7:0]};
				width_n = 7'd8;
			end
			sidu_pkg::SIZE_16: begin
				dvd_sx = {{96{hi_q[15]}}, hi_q[15:0], lo_q[15:0]};
				dv_sx = {{48{dv_q[15]}}, dv_q[15:0]};
				width_n = 7'd16;
			end
			sidu_pkg::SIZE_32: begin
				dvd_sx = {{64{hi_q[31]}}, hi_q[31:0], lo_q[31:0]};
				dv_sx = {{32{dv_q[31]}}, dv_q[31:0]};
				width_n = 7'd32;
			end
			default: begin
				dvd_sx = {hi_q, lo_q};
				dv_sx = dv_q;
				width_n = 7'd64;
			end
		endcase
		dvd_mag = dvd_sx[127] ? (~dvd_sx + 128'd1) : dvd_sx;
		dv_mag = dv_sx[63] ? (~dv_sx + 64'd1) : dv_sx;
		case (size_q)
			sidu_pkg::SIZE_8: begin
				hi_part = {56'd0, dvd_mag[15:8]};
				low_part = {dvd_mag[7:0], 56'd0};
			end
			sidu_pkg::SIZE_16: begin
				hi_part = {48'd0, dvd_mag[31:16]};
				low_part = {dvd_mag[15:0], 48'd0};
			end
			sidu_pkg::SIZE_32: begin
				hi_part = {32'd0, dvd_mag[63:32]};
				low_part = {dvd_mag[31:0], 32'd0};
			end
			default: begin
				hi_part = dvd_mag[127:64];
				low_part = dvd_mag[63:0];
			end
		endcase
	end

	sidu_div_step u_step (
		.rem      (rem_q),
		.next_bit (low_q[63]),
		.dmag     (dmag_q),
		.res      (step)
	);

	always_comb begin
		case (size_q)
			sidu_pkg::SIZE_8: begin
				mask = 64'hFF;
				limit = 64'h7F;
			end
			sidu_pkg::SIZE_16: begin
				mask = 64'hFFFF;
				limit = 64'h7FFF;
			end
			sidu_pkg::SIZE_32: begin
				mask = 64'hFFFF_FFFF;
				limit = 64'h7FFF_FFFF;
			end
			default: begin
				mask = 64'hFFFF_FFFF_FFFF_FFFF;
				limit = 64'h7FFF_FFFF_FFFF_FFFF;
			end
		endcase
		limit = limit + {63'd0, qneg_q};
		q_signed = (qneg_q ? (~low_q + 64'd1) : low_q) & mask;
		r_signed = (vneg_q ? (~rem_q + 64'd1) : rem_q) & mask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			status_q <= sidu_pkg::STATUS_OK;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_FIX) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (zero_q || rem_q >= dmag_q) begin
						state_q <= ST_FIX;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (count_q == 7'd1) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
						if (zero_q) begin
							status_q <= sidu_pkg::STATUS_DIV_ZERO;
						end else if (rem_q >= dmag_q || low_q > limit) begin
							status_q <= sidu_pkg::STATUS_OVERFLOW;
						end else begin
							status_q <= sidu_pkg::STATUS_OK;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// In the fix state an overflow found before the loop is still visible as
	// a partial remainder not below the divisor; after the loop it never is.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					size_q <= op_size;
					lo_q <= dividend_low;
					hi_q <= dividend_high;
					dv_q <= divisor_value;
				end
			end
			ST_PREP: begin
				rem_q <= hi_part;
				low_q <= low_part;
				dmag_q <= dv_mag;
				vneg_q <= dvd_sx[127];
				qneg_q <= dvd_sx[127] ^ dv_sx[63];
				zero_q <= (dv_sx == 64'd0);
				count_q <= width_n;
			end
			ST_DIV: begin
				rem_q <= step.rem_next;
				low_q <= {low_q[62:0], step.quo_bit};
				count_q <= count_q - 7'd1;
			end
			ST_FIX: begin
				if (out_free) begin
					if (zero_q || rem_q >= dmag_q || low_q > limit) begin
						quotient_q <= 64'd0;
						remainder_q <= 64'd0;
					end else begin
						quotient_q <= q_signed;
						remainder_q <= r_signed;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule
